// ----- rtl/deq_pkg.sv -----
package deq_pkg;

    localparam int DEFAULT_DEPTH      = 32;
    localparam int DEFAULT_DATA_WIDTH = 32;

    typedef enum logic [2:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_LIST_FWD   = 3'd4,
        OP_LIST_BWD   = 3'd5,
        OP_COUNT      = 3'd6,
        OP_INVALID    = 3'd7
    } op_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_UNDERFLOW = 3'd1,
        ST_EMPTY     = 3'd2,
        ST_OVERFLOW  = 3'd3,
        ST_INVALID   = 3'd4
    } st_t;

    typedef enum logic [1:0] {
        SRC_ZERO = 2'd0,
        SRC_PUSH = 2'd1,
        SRC_READ = 2'd2
    } src_t;

    typedef struct packed {
        logic [2:0]          op;
        logic signed [31:0]  value;
    } req_item_t;

    typedef struct packed {
        logic [2:0]          status;
        logic signed [31:0]  item_value;
        logic [5:0]          occupancy;
        logic                last;
    } rsp_item_t;

    typedef struct packed {
        logic  latch;
        logic  push;
        logic  pop;
        logic  list_start;
        logic  list_next;
        logic  res_load;
        st_t   res_status;
        src_t  res_src;
    } ctrl_cmd_t;

    typedef struct packed {
        op_t   op;
        logic  empty;
        logic  full;
        logic  res_last;
    } dp_stat_t;

endpackage

// ----- rtl/deq_datapath.sv -----
module deq_datapath #(
    parameter int DEPTH      = deq_pkg::DEFAULT_DEPTH,
    parameter int DATA_WIDTH = deq_pkg::DEFAULT_DATA_WIDTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  deq_pkg::req_item_t  req,
    input  deq_pkg::ctrl_cmd_t  cmd,
    output deq_pkg::dp_stat_t   stat,
    output deq_pkg::rsp_item_t  rsp
);
    import deq_pkg::*;

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [DATA_WIDTH-1:0] mem [DEPTH];

    op_t                   op_reg;
    logic signed [31:0]    value_reg;
    logic [IW-1:0]         front_reg;
    logic [IW-1:0]         front_next;
    logic [CW-1:0]         count_reg;
    logic [CW-1:0]         count_next;
    logic [IW-1:0]         idx_reg;
    logic [DATA_WIDTH-1:0] rd_data_reg;
    st_t                   res_status_reg;
    logic signed [31:0]    res_item_reg;
    logic                  res_last_reg;

    logic                  rd_en;
    logic [IW-1:0]         rd_off;
    logic [IW-1:0]         rd_addr;
    logic [IW-1:0]         wr_addr;
    logic [IW-1:0]         list_sel;
    logic [IW-1:0]         front_dec;
    logic [IW-1:0]         count_last;
    logic                  list_last;
    logic signed [63:0]    value_wide;
    logic [DATA_WIDTH-1:0] store_val;
    logic signed [63:0]    store_wide;
    logic signed [63:0]    read_wide;

    function automatic logic [IW-1:0] ring_pos(input logic [IW-1:0] base,
                                               input logic [IW-1:0] off);
        logic [IW:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= (IW + 1)'(DEPTH)) begin
            sum = sum - (IW + 1)'(DEPTH);
        end
        return sum[IW-1:0];
    endfunction

    assign value_wide = 64'(value_reg);
    assign store_val  = value_wide[DATA_WIDTH-1:0];
    assign store_wide = 64'(signed'(store_val));
    assign read_wide  = 64'(signed'(rd_data_reg));

    assign count_last = IW'(count_reg - CW'(1));
    assign front_dec  = (front_reg == '0) ? IW'(DEPTH - 1) : front_reg - IW'(1);
    assign list_last  = (CW'(idx_reg) + CW'(1)) == count_reg;
    assign rd_en      = cmd.pop | cmd.list_start | cmd.list_next;
    assign list_sel   = cmd.list_start ? '0 : idx_reg + IW'(1);

    always_comb
    begin
        if (cmd.pop) begin
            rd_off = (op_reg == OP_POP_FRONT) ? '0 : count_last;
        end else if (op_reg == OP_LIST_FWD) begin
            rd_off = list_sel;
        end else begin
            rd_off = count_last - list_sel;
        end
        rd_addr = ring_pos(front_reg, rd_off);
        wr_addr = (op_reg == OP_PUSH_FRONT) ? front_dec
                                            : ring_pos(front_reg, IW'(count_reg));
    end

    always_comb
    begin
        front_next = front_reg;
        count_next = count_reg;
        if (cmd.push) begin
            count_next = count_reg + CW'(1);
            if (op_reg == OP_PUSH_FRONT) begin
                front_next = front_dec;
            end
        end else if (cmd.pop) begin
            count_next = count_reg - CW'(1);
            if (op_reg == OP_POP_FRONT) begin
                front_next = ring_pos(front_reg, IW'(1));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            front_reg <= '0;
            count_reg <= '0;
        end else begin
            front_reg <= front_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push) begin
            mem[wr_addr] <= store_val;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch) begin
            op_reg    <= op_t'(req.op);
            value_reg <= req.value;
        end
        if (cmd.list_start) begin
            idx_reg <= '0;
        end else if (cmd.list_next) begin
            idx_reg <= idx_reg + IW'(1);
        end
        if (cmd.res_load) begin
            res_status_reg <= cmd.res_status;
            unique case (cmd.res_src)
                SRC_PUSH: res_item_reg <= store_wide[31:0];
                SRC_READ: res_item_reg <= read_wide[31:0];
                default:  res_item_reg <= '0;
            endcase
            if (cmd.res_src == SRC_READ &&
                (op_reg == OP_LIST_FWD || op_reg == OP_LIST_BWD)) begin
                res_last_reg <= list_last;
            end else begin
                res_last_reg <= 1'b1;
            end
        end
    end

    assign stat.op       = op_reg;
    assign stat.empty    = (count_reg == '0);
    assign stat.full     = (count_reg == CW'(DEPTH));
    assign stat.res_last = res_last_reg;

    assign rsp.status     = res_status_reg;
    assign rsp.item_value = res_item_reg;
    assign rsp.occupancy  = 6'(count_reg);
    assign rsp.last       = res_last_reg;

endmodule

// ----- rtl/deq_ctrl.sv -----
module deq_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    input  deq_pkg::dp_stat_t   stat,
    output deq_pkg::ctrl_cmd_t  cmd
);
    import deq_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_FETCH,
        S_SEND
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign req_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '0;
        cmd.res_status = ST_OK;
        cmd.res_src    = SRC_ZERO;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (req_valid) begin
                    cmd.latch  = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                state_next = S_SEND;
                unique case (stat.op)
                    OP_PUSH_FRONT, OP_PUSH_BACK: begin
                        cmd.res_load = 1'b1;
                        if (stat.full) begin
                            cmd.res_status = ST_OVERFLOW;
                        end else begin
                            cmd.push    = 1'b1;
                            cmd.res_src = SRC_PUSH;
                        end
                    end
                    OP_POP_FRONT, OP_POP_BACK: begin
                        if (stat.empty) begin
                            cmd.res_load   = 1'b1;
                            cmd.res_status = ST_UNDERFLOW;
                        end else begin
                            cmd.pop    = 1'b1;
                            state_next = S_FETCH;
                        end
                    end
                    OP_LIST_FWD, OP_LIST_BWD: begin
                        if (stat.empty) begin
                            cmd.res_load   = 1'b1;
                            cmd.res_status = ST_EMPTY;
                        end else begin
                            cmd.list_start = 1'b1;
                            state_next     = S_FETCH;
                        end
                    end
                    OP_COUNT: begin
                        cmd.res_load = 1'b1;
                    end
                    OP_INVALID: begin
                        cmd.res_load   = 1'b1;
                        cmd.res_status = ST_INVALID;
                    end
                endcase
            end
            S_FETCH: begin
                cmd.res_load = 1'b1;
                cmd.res_src  = SRC_READ;
                state_next   = S_SEND;
            end
            S_SEND: begin
                if (rsp_ready) begin
                    if (stat.res_last) begin
                        state_next = S_IDLE;
                    end else begin
                        cmd.list_next = 1'b1;
                        state_next    = S_FETCH;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
            rsp_valid <= 1'b0;
        end else begin
            state_reg <= state_next;
            rsp_valid <= (state_next == S_SEND);
        end
    end

endmodule

// ----- rtl/double_ended_queue.sv -----
// Simple requests (push, count, failed operations, invalid) go from acceptance via EXEC to
// SEND, where the result is shown; a pop also passes FETCH because of the registered read.
// A listing sends its entries one at a time via FETCH and SEND, each waiting for rsp_ready,
// as the memory read port feeds the single result register; no request is taken until done.
// Reset (asynchronous, active low) clears the front index, entry count and control state;
// the entry memory is not cleared and needs no clearing pass.
module double_ended_queue #(
    parameter int DEPTH      = deq_pkg::DEFAULT_DEPTH,
    parameter int DATA_WIDTH = deq_pkg::DEFAULT_DATA_WIDTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  deq_pkg::req_item_t  req,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output deq_pkg::rsp_item_t  rsp
);
    import deq_pkg::*;

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    deq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    deq_datapath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .cmd   (cmd),
        .stat  (stat),
        .rsp   (rsp)
    );

`ifndef SYNTHESIS
    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        !(req_ready && rsp_valid))
        else $error("Request and result channels are active together.");

    a_list_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_ready && !rsp.last) |=> !req_ready)
        else $error("Request taken before the listing finished.");

    a_fail_last: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.status != 3'(ST_OK)) |-> (rsp.last && rsp.item_value == '0))
        else $error("Failed transaction is not a single zero result.");

    a_no_echo: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !rsp_valid)
        else $error("Result appeared in the cycle after acceptance.");
`endif

endmodule
